/* hdl/cmdfw_pkg.sv */
package cmdfw_pkg;

   // request kinds, carried on req_tuser
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BODY  = 2'd1,
      CMD_RX    = 2'd2,
      CMD_TICK  = 2'd3
   } command_type;

   // final command status codes
   typedef enum logic [1:0] {
      ST_ACK     = 2'd0,
      ST_NACK    = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   // work handed from the front to the back
   typedef enum logic [1:0] {
      JOB_START  = 2'd0,
      JOB_BODY   = 2'd1,
      JOB_STATUS = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         trailer;   // append checksum, CR, LF
      logic [7:0]   data;      // id for start, byte for body
      logic [15:0]  length;
      logic [7:0]   checksum;
      status_type   status;
   } job_type;

   localparam logic [7:0] SYNC0_BYTE = 8'hA0;
   localparam logic [7:0] SYNC1_BYTE = 8'hA1;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] LF_BYTE    = 8'h0A;
   localparam logic [7:0] ACK_BYTE   = 8'h83;
   localparam logic [7:0] NACK_BYTE  = 8'h84;

   localparam int TIMEOUT_RESET = 1000;

endpackage

/* hdl/cmdfw_front.sv */
module cmdfw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cmdfw_pkg::command_type command,
   input  logic [7:0]            message_id,
   input  logic [15:0]           body_length,
   input  logic [7:0]            data_byte,
   input  logic [15:0]           timeout_ticks,
   output logic                  push,
   output cmdfw_pkg::job_type    job
);
   import cmdfw_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BODY = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  pending_id_ff, pending_id_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  previous_rx_ff, previous_rx_in;
   logic        header_seen_ff, header_seen_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic [7:0]  new_xor;
   logic [15:0] new_left;
   logic        hdr_next;
   logic [15:0] tick_count;

   always_comb begin
      phase_in       = phase_ff;
      pending_id_in  = pending_id_ff;
      running_xor_in = running_xor_ff;
      bytes_left_in  = bytes_left_ff;
      previous_rx_in = previous_rx_ff;
      header_seen_in = header_seen_ff;
      elapsed_in     = elapsed_ff;
      push           = 1'b0;
      job            = '0;
      new_xor        = running_xor_ff ^ data_byte;
      new_left       = bytes_left_ff - 16'd1;
      hdr_next       = header_seen_ff |
                       ((previous_rx_ff == SYNC0_BYTE) && (data_byte == SYNC1_BYTE));
      tick_count     = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;

      case (command)
         CMD_START: begin
            pending_id_in  = message_id;
            running_xor_in = message_id;
            bytes_left_in  = body_length;
            push           = 1'b1;
            job.kind       = JOB_START;
            job.data       = message_id;
            job.length     = body_length;
            job.checksum   = message_id;
            job.trailer    = (body_length == 16'd0);
            if (body_length == 16'd0) begin
               phase_in       = PH_WAIT;
               previous_rx_in = '0;
               header_seen_in = 1'b0;
               elapsed_in     = '0;
            end else begin
               phase_in = PH_BODY;
            end
         end
         CMD_BODY: begin
            if (phase_ff == PH_BODY) begin
               running_xor_in = new_xor;
               bytes_left_in  = new_left;
               push           = 1'b1;
               job.kind       = JOB_BODY;
               job.data       = data_byte;
               job.checksum   = new_xor;
               job.trailer    = (new_left == 16'd0);
               if (new_left == 16'd0) begin
                  phase_in       = PH_WAIT;
                  previous_rx_in = '0;
                  header_seen_in = 1'b0;
                  elapsed_in     = '0;
               end
            end
         end
         CMD_RX: begin
            if (phase_ff == PH_WAIT) begin
               header_seen_in = hdr_next;
               previous_rx_in = data_byte;
               if (hdr_next && ((previous_rx_ff == ACK_BYTE) ||
                                (previous_rx_ff == NACK_BYTE))) begin
                  push     = 1'b1;
                  job.kind = JOB_STATUS;
                  phase_in = PH_IDLE;
                  if (data_byte != pending_id_ff)
                     job.status = ST_UNKNOWN;
                  else if (previous_rx_ff == ACK_BYTE)
                     job.status = ST_ACK;
                  else
                     job.status = ST_NACK;
               end
            end
         end
         CMD_TICK: begin
            if (phase_ff == PH_WAIT) begin
               elapsed_in = tick_count;
               if (tick_count >= timeout_ticks) begin
                  push       = 1'b1;
                  job.kind   = JOB_STATUS;
                  job.status = ST_TIMEOUT;
                  phase_in   = PH_IDLE;
               end
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pending_id_ff  <= '0;
         running_xor_ff <= '0;
         bytes_left_ff  <= '0;
         previous_rx_ff <= '0;
         header_seen_ff <= 1'b0;
         elapsed_ff     <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         pending_id_ff  <= pending_id_in;
         running_xor_ff <= running_xor_in;
         bytes_left_ff  <= bytes_left_in;
         previous_rx_ff <= previous_rx_in;
         header_seen_ff <= header_seen_in;
         elapsed_ff     <= elapsed_in;
      end
   end

endmodule

/* hdl/cmdfw_queue.sv */
module cmdfw_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cmdfw_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cmdfw_pkg::job_type head_job
);
   import cmdfw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

/* hdl/cmdfw_back.sv */
module cmdfw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  cmdfw_pkg::job_type job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_status,
   output logic [7:0]         rsp_tx_byte,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   import cmdfw_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic       is_status_ff, is_status_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic       load;
   logic [2:0] idx;
   logic       last_step;

   // body jobs reuse the tail of the start sequence: id slot onward
   always_comb begin
      idx       = (job.kind == JOB_BODY) ? step_ff + 3'd4 : step_ff;
      last_step = 1'b0;
      tx_byte_in = '0;
      status_in  = '0;
      is_status_in = 1'b0;
      case (job.kind)
         JOB_STATUS: begin
            is_status_in = 1'b1;
            status_in    = job.status;
            last_step    = 1'b1;
         end
         JOB_START, JOB_BODY: begin
            last_step = ((idx == 3'd4) && !job.trailer) || (idx == 3'd7);
            case (idx)
               3'd0:    tx_byte_in = SYNC0_BYTE;
               3'd1:    tx_byte_in = SYNC1_BYTE;
               3'd2:    tx_byte_in = job.length[15:8];
               3'd3:    tx_byte_in = job.length[7:0];
               3'd4:    tx_byte_in = job.data;
               3'd5:    tx_byte_in = job.checksum;
               3'd6:    tx_byte_in = CR_BYTE;
               default: tx_byte_in = LF_BYTE;
            endcase
         end
         default: begin
            last_step = 1'b1;
         end
      endcase

      load    = job_valid && (!valid_ff || rsp_ready);
      pop     = load && last_step;
      last_in = last_step;
      step_in = step_ff;
      if (load)
         step_in = last_step ? 3'd0 : step_ff + 3'd1;
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp_ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         is_status_ff <= is_status_in;
         tx_byte_ff   <= tx_byte_in;
         status_ff    <= status_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_is_status = is_status_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

/* hdl/command_frame_and_ack_waiter_core.sv */
// Channel    | Direction | Carries
// req_*      | in        | tuser command, tdata id / length / byte
// rsp_*      | out       | tuser is_status, tdata tx_byte / status, tlast
// csr_*      | in/out    | APB register timeout_ticks at 0x0
//
// The front takes one request per clock while the job queue has room and
// updates phase, checksum and scanner state in that same cycle.
// The back emits one result per clock unless rsp_tready stalls it: 5 or 8 for
// a start, 1 or 4 for a body byte, 1 for a status; other requests queue no job.
// Output register on the back; a stalled rsp side fills the queue, then
// req_tready drops. Synchronous active-high reset, no clearing pass.
module command_frame_and_ack_waiter_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] message_id, [23:8] body_length,
                                    // [31:24] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] tx_byte, [9:8] status, rest zero
   output logic        rsp_tuser,   // [0] is_status
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cmdfw_pkg::*;

   logic [15:0] timeout_ff;
   logic        cfg_write;

   logic        accept;
   logic        push;
   job_type     push_job;
   logic        queue_full;
   logic        job_valid;
   job_type     head_job;
   logic        pop;

   logic        out_is_status;
   logic [7:0]  out_tx_byte;
   logic [1:0]  out_status;

   // register 0 lives in the low word; anything at 0x4 and up is ignored
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, timeout_ff};

   always_ff @(posedge clock) begin
      if (reset)
         timeout_ff <= 16'(TIMEOUT_RESET);
      else if (cfg_write)
         timeout_ff <= csr_pwdata[15:0];
   end

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   cmdfw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (command_type'(req_tuser)),
      .message_id    (req_tdata[7:0]),
      .body_length   (req_tdata[23:8]),
      .data_byte     (req_tdata[31:24]),
      .timeout_ticks (timeout_ff),
      .push          (push),
      .job           (push_job)
   );

   // the front only commits a job on an accepted request
   cmdfw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push && accept),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (job_valid),
      .head_job   (head_job)
   );

   cmdfw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_is_status (out_is_status),
      .rsp_tx_byte   (out_tx_byte),
      .rsp_status    (out_status),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_status, out_tx_byte};
   assign rsp_tuser = out_is_status;

`ifndef SYNTH
   // a request is never accepted into a full queue
   assert property (@(posedge clock) disable iff (reset) accept |-> !queue_full)
      else $error("request accepted with job queue full");

   // status results are single and carry a zero frame byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata[7:0] == 8'd0)))
      else $error("status result malformed");

   // a frame byte result carries a zero status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[9:8] == 2'd0))
      else $error("frame byte result with status set");

   // reset leaves no queued work and no pending result
   assert property (@(posedge clock) reset |=> (!job_valid && !rsp_tvalid))
      else $error("work left after reset");
`endif

endmodule
